/* sv/rdx_pkg.sv */
`default_nettype none

package rdx_pkg;

	localparam int SLOTS      = 1024;
	localparam int SLOT_BITS  = $clog2(SLOTS);
	localparam int MAX_COUNT  = 4096;
	localparam int COUNT_BITS = $clog2(MAX_COUNT + 1);
	localparam int VALUE_BITS = 16;
	localparam int DELTA_BITS = 16;
	localparam int CMD_BITS   = 2;

	typedef logic [CMD_BITS-1:0]          cmd_t;
	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [DELTA_BITS-1:0] delta_t;
	typedef logic [COUNT_BITS-1:0]        count_t;
	typedef logic [SLOT_BITS-1:0]         slot_t;

	localparam cmd_t CMD_ACC    = 2'd0;
	localparam cmd_t CMD_GRAD   = 2'd1;
	localparam cmd_t CMD_CLEAR  = 2'd2;
	localparam cmd_t CMD_UNUSED = 2'd3;

	localparam count_t MAX_COUNT_C = COUNT_BITS'(MAX_COUNT);
	localparam count_t COUNT_ONE   = COUNT_BITS'(1);
	localparam value_t VALUE_MAX   = {1'b0, {(VALUE_BITS-1){1'b1}}};
	localparam value_t VALUE_MIN   = {1'b1, {(VALUE_BITS-1){1'b0}}};

	typedef struct packed {
		cmd_t   cmd;
		slot_t  slot;
		value_t value;
		delta_t delta;
	} item_t;

	typedef struct packed {
		value_t extremum;
		count_t tie_total;
		delta_t grad;
		logic   zero_count;
	} result_t;

	typedef struct packed {
		logic mode_min;
	} cfg_t;

	typedef struct packed {
		value_t best;
		count_t count;
	} entry_t;

	typedef struct packed {
		logic   rd_en;
		slot_t  rd_addr;
		logic   wr_en;
		slot_t  wr_addr;
		entry_t wr_data;
	} ram_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

/* sv/rdx_stream_if.sv */
`default_nettype none

interface rdx_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* sv/rdx_ram.sv */
`default_nettype none

module rdx_ram import rdx_pkg::*; (
	input  wire      clk,
	input  ram_req_t req,
	output entry_t   rd_data
);

	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

`default_nettype wire

/* sv/rdx_div.sv */
`default_nettype none

// Unsigned restoring divider, one quotient bit per cycle.
module rdx_div import rdx_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  logic                   start,
	input  logic [DELTA_BITS-1:0]  dividend,
	input  count_t                 divisor,
	output logic [DELTA_BITS-1:0]  quotient,
	output div_stat_t              stat
);

	localparam int STEP_BITS = $clog2(DELTA_BITS + 1);
	localparam logic [STEP_BITS-1:0] STEPS   = STEP_BITS'(DELTA_BITS);
	localparam logic [STEP_BITS-1:0] LAST    = STEP_BITS'(1);

	logic [DELTA_BITS-1:0] quo_q;
	count_t                rem_q;
	count_t                dvs_q;
	logic [STEP_BITS-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [COUNT_BITS:0]   trial;
	logic [COUNT_BITS:0]   diff;
	logic                  fits;

	assign trial = {rem_q, quo_q[DELTA_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DELTA_BITS-2:0], fits};
			rem_q <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= STEPS;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - LAST;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider started while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q && !done_q)
		else $error("divider did not enter busy after start");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && cnt_q == LAST && !start |=> done_q && !busy_q)
		else $error("divider did not finish on last step");

endmodule

`default_nettype wire

/* sv/reduce_extremum_tie_count.sv */
`default_nettype none

// Channel  Role    Payload                               Handshake
// item     sink    cmd, slot, value, delta               valid/ready
// result   source  extremum, tie_total, grad, zero_count valid/ready
// cfg      sink    mode_min                              valid/ready
//
// One request at a time. Each request reads the table, then its result is
// registered once the output register is free; accumulate and reset-slot also
// write back. A gradient that hits the extremum with a nonzero count first runs
// the divider: its start and its 16 quotient steps. The next request is taken
// while a result still waits in the output register. No clearing pass after
// reset: a slot holds nothing meaningful until a reset-slot request writes it.
module reduce_extremum_tie_count import rdx_pkg::*; (
	input  wire           clk,
	input  wire           arst_n,
	rdx_stream_if.sink    item,
	rdx_stream_if.source  result,
	rdx_stream_if.sink    cfg
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	logic [1:0] state_q;
	logic       mode_min_q;
	logic       out_valid_q;
	result_t    res_q;

	cmd_t       cmd_q;
	slot_t      slot_q;
	value_t     value_q;
	delta_t     delta_q;

	ram_req_t   ram_req;
	entry_t     rd;
	entry_t     upd;
	logic       wr_need;
	logic       zc;
	logic       hit;
	logic       better;
	logic       accept;
	logic       load_ok;
	logic       load_exec;
	logic       load_div;

	logic                  div_start;
	logic [DELTA_BITS-1:0] div_mag;
	logic [DELTA_BITS-1:0] div_quo;
	div_stat_t             div_stat;
	delta_t                grad_val;

	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;
	assign load_ok    = !out_valid_q || result.ready;

	rdx_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd)
	);

	assign better = mode_min_q ? ($signed(value_q) < $signed(rd.best))
	                           : ($signed(value_q) > $signed(rd.best));

	always_comb begin
		upd     = rd;
		wr_need = 1'b0;
		zc      = 1'b0;
		hit     = 1'b0;
		case (cmd_q)
			CMD_ACC: begin
				wr_need = 1'b1;
				if (value_q == rd.best) begin
					if (rd.count < MAX_COUNT_C) begin
						upd.count = rd.count + COUNT_ONE;
					end
				end else if (better) begin
					upd.best  = value_q;
					upd.count = COUNT_ONE;
				end
			end
			CMD_GRAD: begin
				zc  = (rd.count == '0);
				hit = !zc && (value_q == rd.best);
			end
			CMD_CLEAR: begin
				wr_need   = 1'b1;
				upd.best  = mode_min_q ? VALUE_MAX : VALUE_MIN;
				upd.count = '0;
			end
			default: begin
			end
		endcase
	end

	assign div_start = (state_q == ST_EXEC) && hit;
	assign load_exec = (state_q == ST_EXEC) && !hit && load_ok;
	assign load_div  = (state_q == ST_DIV) && div_stat.done && load_ok;

	assign ram_req.rd_en   = accept;
	assign ram_req.rd_addr = item.data.slot;
	assign ram_req.wr_en   = load_exec && wr_need;
	assign ram_req.wr_addr = slot_q;
	assign ram_req.wr_data = upd;

	// divide the magnitude, restore the sign: truncation toward zero
	assign div_mag  = delta_q[DELTA_BITS-1] ? (~delta_q + 1'b1) : delta_q;
	assign grad_val = delta_q[DELTA_BITS-1] ? delta_t'(~div_quo + 1'b1) : delta_t'(div_quo);

	rdx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_mag),
		.divisor  (rd.count),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= item.data.cmd;
			slot_q  <= item.data.slot;
			value_q <= item.data.value;
			delta_q <= item.data.delta;
		end
		if (load_exec) begin
			res_q.extremum   <= upd.best;
			res_q.tie_total  <= upd.count;
			res_q.grad       <= '0;
			res_q.zero_count <= zc;
		end else if (load_div) begin
			res_q.extremum   <= rd.best;
			res_q.tie_total  <= rd.count;
			res_q.grad       <= grad_val;
			res_q.zero_count <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_min_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				mode_min_q <= cfg.data.mode_min;
			end
			if (load_exec || load_div) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end else if (load_exec) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (load_div) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = res_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("request accepted but no table lookup followed");
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		ram_req.wr_en |=> out_valid_q)
		else $error("table written without a result");
	a_div_only_grad: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> cmd_q == CMD_GRAD && !div_stat.busy)
		else $error("divider started outside a gradient request");
	a_zero_count_grad: assert property (@(posedge clk) disable iff (!arst_n)
		load_div |=> !res_q.zero_count && res_q.tie_total != '0)
		else $error("divided result carries a zero count");

endmodule

`default_nettype wire
